### rtl/core/filtered_group_aggregate_macros.svh
// Assertion macros used by the filtered group aggregate RTL.
`ifndef FILTERED_GROUP_AGGREGATE_MACROS_SVH
`define FILTERED_GROUP_AGGREGATE_MACROS_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define FGA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the antecedent implies the consequent in the next cycle.
`define FGA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/fga_pkg.sv
// Package with the types and constants of the filtered group aggregate.
package fga_pkg;

   localparam int NUM_GROUPS_DEF = 6;
   localparam logic [26:0] CUTOFF_RESET = 27'd19980901;

   localparam int W_QTY = 48;
   localparam int W_PRICE = 56;
   localparam int W_DPRICE = 62;
   localparam int W_CHARGE = 63;
   localparam int W_DISC = 48;
   localparam int W_COUNT = 40;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 320;

   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [6:0] PCT_FULL = 7'd100;
   localparam logic [7:0] PCT_BASE = 8'd100;

   typedef struct packed {
      logic [W_COUNT-1:0] count;
      logic [W_DISC-1:0] discount;
      logic [W_CHARGE-1:0] charge;
      logic [W_DPRICE-1:0] disc_price;
      logic [W_PRICE-1:0] price;
      logic [W_QTY-1:0] quantity;
   } acc_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL1 = 4'b0010,
      ST_MUL2 = 4'b0100,
      ST_ADD = 4'b1000
   } state_type;

endpackage

### rtl/core/filtered_group_aggregate.sv
// Top level of the filtered group aggregate over line-item records.
//
// Input beats arrive on req_. A beat with req_tuser low is a record: when its
// ship date is at or below the cutoff register, it is added to the group
// return flag plus twice the line status, and it produces no result. A beat
// with req_tuser high reads one group and produces exactly one rsp_ beat with
// its six saturating sums; a group outside the table reads as all zeros.
// The csr_ port writes the ship date cutoff at any edge with csr_wr_en high.
// Each beat goes through the group memory read, the discount multiply,
// the tax multiply, then the saturating add and write back. A new beat is
// accepted only in ST_IDLE, after the last one is through; rsp_tvalid rises
// when a read leaves ST_ADD. The memory port is used by one beat at a time.
// Reset clears the cutoff to its default, marks every group empty so it
// reads as zero, and drops any pending result; no clearing pass is needed.
// A stalled rsp_ channel holds its result in the output register; only a
// following read waits for it, and records keep flowing.
`include "filtered_group_aggregate_macros.svh"

module filtered_group_aggregate #(
   parameter int NUM_GROUPS = fga_pkg::NUM_GROUPS_DEF
) (
   input logic clock,
   input logic reset,
   input logic csr_wr_en,
   input logic [26:0] csr_wr_data,
   input logic req_tvalid,
   output logic req_tready,
   // ship_date, return_flag, line_status, quantity, extended_price, discount,
   // tax, read_group, zero fill.
   input logic [fga_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode.
   input logic req_tuser,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // sum_quantity, sum_price, sum_net_price, sum_charge, sum_discount,
   // record_count, zero fill.
   output logic [fga_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(NUM_GROUPS);
   localparam int ENTRY_W = $bits(fga_pkg::acc_entry_type);

   fga_pkg::state_type state_ff, state_in;
   logic [26:0] cutoff_ff;
   logic [NUM_GROUPS-1:0] valid_ff, valid_in;
   logic acc_en_ff, acc_en_in;
   logic is_read_ff, is_read_in;
   logic read_ok_ff, read_ok_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [9:0] qty_ff;
   logic [23:0] price_ff;
   logic [6:0] disc_ff;
   logic [6:0] keep_ff, keep_in;
   logic [7:0] taxf_ff;
   logic [30:0] dprice_ff;
   logic [38:0] charge_ff;
   logic rsp_tvalid_ff, rsp_tvalid_in;
   fga_pkg::acc_entry_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic [26:0] f_ship;
   logic f_rf;
   logic [1:0] f_ls;
   logic [2:0] f_rg;
   logic [6:0] f_disc;
   logic [2:0] grp;
   logic [2:0] sel_grp;
   logic ram_wr_en;
   logic [ENTRY_W-1:0] ram_rd_data;
   fga_pkg::acc_entry_type old_entry, new_entry;
   logic [fga_pkg::W_QTY:0] s_qty;
   logic [fga_pkg::W_PRICE:0] s_price;
   logic [fga_pkg::W_DPRICE:0] s_dprice;
   logic [fga_pkg::W_CHARGE:0] s_charge;
   logic [fga_pkg::W_DISC:0] s_disc;
   logic [fga_pkg::W_COUNT:0] s_count;

   assign f_ship = req_tdata[26:0];
   assign f_rf = req_tdata[27];
   assign f_ls = req_tdata[29:28];
   assign f_disc = req_tdata[70:64];
   assign f_rg = req_tdata[80:78];
   assign grp = {f_ls, 1'b0} + {2'b00, f_rf};
   assign sel_grp = (req_tuser == fga_pkg::OP_READ) ? f_rg : grp;

   assign req_tready = (state_ff == fga_pkg::ST_IDLE) && !reset;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      is_read_in = is_read_ff;
      read_ok_in = read_ok_ff;
      acc_en_in = acc_en_ff;
      addr_in = addr_ff;
      keep_in = (f_disc >= fga_pkg::PCT_FULL) ? 7'd0 : fga_pkg::PCT_FULL - f_disc;
      if (accept) begin
         is_read_in = (req_tuser == fga_pkg::OP_READ);
         read_ok_in = 32'(f_rg) < 32'(NUM_GROUPS);
         acc_en_in = (req_tuser == fga_pkg::OP_ACCUM) && (f_ship <= cutoff_ff)
            && (32'(grp) < 32'(NUM_GROUPS));
         addr_in = AW'(sel_grp);
      end
   end

   fga_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(NUM_GROUPS)
   ) u_acc_ram (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(addr_ff),
      .wr_data(new_entry),
      .rd_en(accept),
      .rd_addr(addr_in),
      .rd_data(ram_rd_data)
   );

   assign old_entry = valid_ff[addr_ff] ? fga_pkg::acc_entry_type'(ram_rd_data) : '0;

   always_comb begin
      s_qty = {1'b0, old_entry.quantity} + (fga_pkg::W_QTY + 1)'(qty_ff);
      s_price = {1'b0, old_entry.price} + (fga_pkg::W_PRICE + 1)'(price_ff);
      s_dprice = {1'b0, old_entry.disc_price} + (fga_pkg::W_DPRICE + 1)'(dprice_ff);
      s_charge = {1'b0, old_entry.charge} + (fga_pkg::W_CHARGE + 1)'(charge_ff);
      s_disc = {1'b0, old_entry.discount} + (fga_pkg::W_DISC + 1)'(disc_ff);
      s_count = {1'b0, old_entry.count} + (fga_pkg::W_COUNT + 1)'(1'b1);
      new_entry.quantity = s_qty[fga_pkg::W_QTY] ? '1 : s_qty[fga_pkg::W_QTY-1:0];
      new_entry.price = s_price[fga_pkg::W_PRICE] ? '1 : s_price[fga_pkg::W_PRICE-1:0];
      new_entry.disc_price = s_dprice[fga_pkg::W_DPRICE] ? '1
         : s_dprice[fga_pkg::W_DPRICE-1:0];
      new_entry.charge = s_charge[fga_pkg::W_CHARGE] ? '1 : s_charge[fga_pkg::W_CHARGE-1:0];
      new_entry.discount = s_disc[fga_pkg::W_DISC] ? '1 : s_disc[fga_pkg::W_DISC-1:0];
      new_entry.count = s_count[fga_pkg::W_COUNT] ? '1 : s_count[fga_pkg::W_COUNT-1:0];
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      ram_wr_en = 1'b0;
      rsp_data_in = rsp_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      unique case (state_ff)
         fga_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = fga_pkg::ST_MUL1;
            end
         end
         fga_pkg::ST_MUL1: begin
            state_in = fga_pkg::ST_MUL2;
         end
         fga_pkg::ST_MUL2: begin
            state_in = fga_pkg::ST_ADD;
         end
         fga_pkg::ST_ADD: begin
            if (is_read_ff) begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_data_in = read_ok_ff ? old_entry : '0;
                  rsp_tvalid_in = 1'b1;
                  state_in = fga_pkg::ST_IDLE;
               end
            end else begin
               if (acc_en_ff) begin
                  ram_wr_en = 1'b1;
                  valid_in[addr_ff] = 1'b1;
               end
               state_in = fga_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fga_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fga_pkg::ST_IDLE;
         cutoff_ff <= fga_pkg::CUTOFF_RESET;
         valid_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
         acc_en_ff <= 1'b0;
         is_read_ff <= 1'b0;
         read_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            cutoff_ff <= csr_wr_data;
         end
         valid_ff <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         acc_en_ff <= acc_en_in;
         is_read_ff <= is_read_in;
         read_ok_ff <= read_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         qty_ff <= req_tdata[39:30];
         price_ff <= req_tdata[63:40];
         disc_ff <= f_disc;
         keep_ff <= keep_in;
         taxf_ff <= fga_pkg::PCT_BASE + {1'b0, req_tdata[77:71]};
      end
      if (state_ff == fga_pkg::ST_MUL1) begin
         dprice_ff <= 31'(price_ff) * 31'(keep_ff);
      end
      if (state_ff == fga_pkg::ST_MUL2) begin
         charge_ff <= 39'(dprice_ff) * 39'(taxf_ff);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = {3'b000, rsp_data_ff};

   `FGA_ASSERT_NEXT(a_accept_starts, clock, reset, accept,
      state_ff == fga_pkg::ST_MUL1, "Accepted beat did not start the read stage.")
   `FGA_ASSERT_SAME(a_rsp_from_add, clock, reset, $rose(rsp_tvalid_ff),
      $past(state_ff) == fga_pkg::ST_ADD && $past(is_read_ff), "Result without a read beat.")
   `FGA_ASSERT_SAME(a_write_no_read, clock, reset, ram_wr_en,
      !is_read_ff && !accept, "Group write overlaps a read beat.")

endmodule

### rtl/core/fga_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fga_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic rd_en,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
